@@ hw/rtl/lrutd_pkg.sv @@
// Package for the LRU tag directory: request codes and default sizes.
// No dependencies.
`default_nettype none
package lrutd_pkg;
  localparam int unsigned Entries = 16;
  localparam int unsigned KeyW = 32;
  localparam int unsigned SlotW = 4;
  localparam int unsigned TypeW = 3;

  localparam logic [TypeW-1:0] ReqLookup = 3'd0;
  localparam logic [TypeW-1:0] ReqUpdate = 3'd1;
  localparam logic [TypeW-1:0] ReqOldest = 3'd2;
  localparam logic [TypeW-1:0] ReqOldValid = 3'd3;
  localparam logic [TypeW-1:0] ReqNewer = 3'd4;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StFix  = 5'b00100,
    StDone = 5'b01000,
    StOut  = 5'b10000
  } state_e;
endpackage
`default_nettype wire

@@ hw/rtl/lru_tag_directory.sv @@
// Top level of the LRU tag directory: sequencer, tag memory and rank/valid
// registers. Depends on lrutd_pkg.
// Sequence: after a request transfer the entries are scanned in order, then the
// fix state decides, the done state updates the ranks and the result is offered.
// One request at a time: a new request is taken only when idle, after the result.
// Reset: valid marks cleared and slot i given rank i at once; the tag memory
// is not cleared since only valid entries are read.
`default_nettype none
module lru_tag_directory #(
  parameter int unsigned ENTRIES = lrutd_pkg::Entries
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [lrutd_pkg::TypeW-1:0] req_type_i,
  input  wire logic [lrutd_pkg::KeyW-1:0]  key_i,
  input  wire logic [lrutd_pkg::SlotW-1:0] slot_in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             found_o,
  output logic [lrutd_pkg::SlotW-1:0]      slot_out_o,
  output logic [lrutd_pkg::KeyW-1:0]       key_out_o,
  output logic                             created_o
);
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] Last = IW'(ENTRIES - 1);

  lrutd_pkg::state_e st_q, st_d;
  logic [lrutd_pkg::KeyW-1:0] mem [ENTRIES];
  logic [lrutd_pkg::KeyW-1:0] rd_q;
  logic [ENTRIES-1:0] vld_q;
  logic [IW-1:0] rank_q [ENTRIES];
  logic [IW-1:0] idx_q;
  logic [lrutd_pkg::TypeW-1:0] typ_q;
  logic [lrutd_pkg::KeyW-1:0] key_q;
  logic [lrutd_pkg::SlotW-1:0] sin_q;
  logic hit_q, cre_q, fnd_q, wr_q;
  logic [IW-1:0] hslot_q, oldest_q, newer_q, ovs_q;
  logic [IW:0] ovr_q;  // best rank of a valid slot, plus one; 0 = none
  logic [IW-1:0] tgt_q;
  logic chk_q;
  logic [IW-1:0] chk_idx_q;

  // Memory read address: scan index while scanning, target slot in all other states.
  logic [IW-1:0] raddr;
  assign raddr = (st_q == lrutd_pkg::StScan) ? idx_q : tgt_q;
  always_ff @(posedge clk_i) begin
    if (wr_q) mem[tgt_q] <= key_q;
    rd_q <= mem[raddr];
  end

  logic sin_ok;
  assign sin_ok = ({{(32-lrutd_pkg::SlotW){1'b0}}, sin_q} < 32'(ENTRIES));
  logic [IW-1:0] sin_idx;
  assign sin_idx = IW'(sin_q);

  assign in_ready_o = (st_q == lrutd_pkg::StIdle);
  assign out_valid_o = (st_q == lrutd_pkg::StOut);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      lrutd_pkg::StIdle: if (in_valid_i) st_d = lrutd_pkg::StScan;
      lrutd_pkg::StScan: if (idx_q == Last) st_d = lrutd_pkg::StFix;
      lrutd_pkg::StFix:  st_d = lrutd_pkg::StDone;
      lrutd_pkg::StDone: st_d = lrutd_pkg::StOut;
      lrutd_pkg::StOut:  if (out_ready_i) st_d = lrutd_pkg::StIdle;
      default:           st_d = lrutd_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lrutd_pkg::StIdle;
      vld_q <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= IW'(i);
      idx_q <= '0;
      wr_q <= 1'b0;
      chk_q <= 1'b0;
    end else begin
      st_q <= st_d;
      wr_q <= 1'b0;
      // Compare the registered read of the previous scan index.
      chk_q <= (st_q == lrutd_pkg::StScan);
      chk_idx_q <= idx_q;
      if (chk_q && !hit_q && vld_q[chk_idx_q] && rd_q == key_q) begin
        hit_q <= 1'b1;
        hslot_q <= chk_idx_q;
      end
      unique case (st_q)
        lrutd_pkg::StIdle: begin
          idx_q <= '0;
          typ_q <= req_type_i;
          key_q <= key_i;
          sin_q <= slot_in_i;
          hit_q <= 1'b0;
          ovr_q <= '0;
          ovs_q <= '0;
          oldest_q <= '0;
          newer_q <= '0;
        end
        lrutd_pkg::StScan: begin
          idx_q <= idx_q + 1'b1;
          if (rank_q[idx_q] == Last) oldest_q <= idx_q;
          if (vld_q[idx_q] && {1'b0, rank_q[idx_q]} >= ovr_q) begin
            ovr_q <= {1'b0, rank_q[idx_q]} + 1'b1;
            ovs_q <= idx_q;
          end
          if (sin_ok && rank_q[sin_idx] != '0 &&
              rank_q[idx_q] == rank_q[sin_idx] - 1'b1) newer_q <= idx_q;
        end
        lrutd_pkg::StFix: begin
          // Last compare lands this cycle; decide target from registered flags.
          tgt_q <= '0;
          fnd_q <= 1'b0;
          cre_q <= 1'b0;
          if (typ_q == lrutd_pkg::ReqLookup || typ_q == lrutd_pkg::ReqUpdate) begin
            if (chk_q && !hit_q && vld_q[chk_idx_q] && rd_q == key_q) begin
              tgt_q <= chk_idx_q; fnd_q <= 1'b1;
            end else if (hit_q) begin
              tgt_q <= hslot_q; fnd_q <= 1'b1;
            end else if (typ_q == lrutd_pkg::ReqUpdate) begin
              tgt_q <= oldest_q; fnd_q <= 1'b1; cre_q <= 1'b1; wr_q <= 1'b1;
            end
          end else if (typ_q == lrutd_pkg::ReqOldest) begin
            tgt_q <= oldest_q; fnd_q <= vld_q[oldest_q];
          end else if (typ_q == lrutd_pkg::ReqOldValid) begin
            tgt_q <= ovs_q; fnd_q <= (ovr_q != '0);
          end else if (typ_q == lrutd_pkg::ReqNewer) begin
            tgt_q <= newer_q; fnd_q <= sin_ok && rank_q[sin_idx] != '0;
          end
        end
        lrutd_pkg::StDone: begin
          // Age update for lookup hit or update: shift younger ranks.
          if (fnd_q && (typ_q == lrutd_pkg::ReqLookup ||
                        typ_q == lrutd_pkg::ReqUpdate)) begin
            for (int i = 0; i < ENTRIES; i++)
              if (rank_q[i] < rank_q[tgt_q]) rank_q[i] <= rank_q[i] + 1'b1;
            rank_q[tgt_q] <= '0;
            if (cre_q) vld_q[tgt_q] <= 1'b1;
          end
        end
        lrutd_pkg::StOut: ;
        default: ;
      endcase
    end
  end

  // The written key is forwarded; otherwise the registered read is used.
  // While the result waits the read address stays on the target slot.
  logic [lrutd_pkg::KeyW-1:0] kq;
  assign kq = (!fnd_q) ? '0 : cre_q ? key_q : vld_q[tgt_q] ? rd_q : '0;

  assign found_o = fnd_q;
  assign slot_out_o = fnd_q ? lrutd_pkg::SlotW'(tgt_q) : '0;
  assign key_out_o = kq;
  assign created_o = cre_q;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(st_q))
    else $error("state not one-hot");
  a_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && created_o |-> found_o && typ_q == lrutd_pkg::ReqUpdate)
    else $error("created without update");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready during output");
endmodule
`default_nettype wire

@@ tb/sv/lru_tag_directory_checker.sv @@
`timescale 1ns / 1ps
// Checker for the LRU tag directory: watches both channels, keeps its own
// copy of tags, valid marks and age ranks, and compares every result.
// Depends on lrutd_pkg.
module lru_tag_directory_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [lrutd_pkg::TypeW-1:0]     req_type_i,
  input  logic [lrutd_pkg::KeyW-1:0]      key_i,
  input  logic [lrutd_pkg::SlotW-1:0]     slot_in_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic                            found_i,
  input  logic [lrutd_pkg::SlotW-1:0]     slot_out_i,
  input  logic [lrutd_pkg::KeyW-1:0]      key_out_i,
  input  logic                            created_i,
  output int                              pending_o,
  output int                              errors_o
);
  typedef struct packed {
    logic                        found;
    logic [lrutd_pkg::SlotW-1:0] slot;
    logic [lrutd_pkg::KeyW-1:0]  key;
    logic                        created;
  } answer_t;

  logic [lrutd_pkg::KeyW-1:0]  tags [lrutd_pkg::Entries];
  logic                        vld  [lrutd_pkg::Entries];
  logic [lrutd_pkg::SlotW-1:0] rank [lrutd_pkg::Entries];
  answer_t                     answers_q [$];

  function automatic logic [lrutd_pkg::SlotW-1:0] slot_at_rank(int unsigned r);
    for (int i = 0; i < lrutd_pkg::Entries; i++) begin
      if (rank[i] == r) return lrutd_pkg::SlotW'(i);
    end
    return '0;
  endfunction

  task automatic promote(logic [lrutd_pkg::SlotW-1:0] s);
    logic [lrutd_pkg::SlotW-1:0] r;
    r = rank[s];
    for (int i = 0; i < lrutd_pkg::Entries; i++) begin
      if (rank[i] < r) rank[i] = rank[i] + 1'b1;
    end
    rank[s] = '0;
  endtask

  task automatic predict_directory(logic [lrutd_pkg::TypeW-1:0] op,
                                   logic [lrutd_pkg::KeyW-1:0] k,
                                   logic [lrutd_pkg::SlotW-1:0] sin, output answer_t a);
    int hit;
    logic [lrutd_pkg::SlotW-1:0] s;
    a = '0;
    hit = -1;
    case (op)
      lrutd_pkg::ReqLookup, lrutd_pkg::ReqUpdate: begin
        for (int i = lrutd_pkg::Entries - 1; i >= 0; i--) begin
          if (vld[i] && tags[i] == k) hit = i;
        end
        if (hit >= 0) begin
          s = lrutd_pkg::SlotW'(hit);
          promote(s);
          a.found = 1'b1;
        end else if (op == lrutd_pkg::ReqUpdate) begin
          s = slot_at_rank(lrutd_pkg::Entries - 1);
          tags[s] = k;
          vld[s] = 1'b1;
          promote(s);
          a.found = 1'b1;
          a.created = 1'b1;
        end
        if (a.found) begin
          a.slot = s;
          a.key = tags[s];
        end
      end
      lrutd_pkg::ReqOldest: begin
        s = slot_at_rank(lrutd_pkg::Entries - 1);
        if (vld[s]) a = '{1'b1, s, tags[s], 1'b0};
      end
      lrutd_pkg::ReqOldValid: begin
        for (int r = lrutd_pkg::Entries - 1; r >= 0 && !a.found; r--) begin
          s = slot_at_rank(r);
          if (vld[s]) a = '{1'b1, s, tags[s], 1'b0};
        end
      end
      lrutd_pkg::ReqNewer: begin
        if (sin < lrutd_pkg::Entries && rank[sin] != 0) begin
          s = slot_at_rank(rank[sin] - 1);
          a = '{1'b1, s, (vld[s] ? tags[s] : '0), 1'b0};
        end
      end
      default: ;
    endcase
  endtask

  assign pending_o = answers_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t a, want;
    if (!rst_ni) begin
      for (int i = 0; i < lrutd_pkg::Entries; i++) begin
        tags[i] = '0;
        vld[i] = 1'b0;
        rank[i] = lrutd_pkg::SlotW'(i);
      end
      answers_q.delete();
      errors_o = 0;
    end else begin
      // A result and a new request can transfer in the same cycle only when
      // the result belongs to an older request, so check before predicting.
      if (out_valid_i && out_ready_i) begin
        a = '{found_i, slot_out_i, key_out_i, created_i};
        if (answers_q.size() == 0) begin
          $display("%0t: unexpected result found=%0d slot=%0d key=%h created=%0d",
                   $time, a.found, a.slot, a.key, a.created);
          errors_o++;
        end else begin
          want = answers_q.pop_front();
          if (a.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, a.found);
            errors_o++;
          end
          if (a.slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, a.slot);
            errors_o++;
          end
          if (a.key !== want.key) begin
            $display("%0t: key expected %h actual %h", $time, want.key, a.key);
            errors_o++;
          end
          if (a.created !== want.created) begin
            $display("%0t: created expected %0d actual %0d", $time, want.created,
                     a.created);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_directory(req_type_i, key_i, slot_in_i, want);
        answers_q.push_back(want);
      end
    end
  end
endmodule

@@ tb/sv/tb_lru_tag_directory.sv @@
`timescale 1ns / 1ps
// Top of the LRU tag directory testbench: clock, reset, directed and random
// requests, random stalls and the verdict. Depends on lrutd_pkg, the block
// and lru_tag_directory_checker.
module tb_lru_tag_directory;
  localparam logic [lrutd_pkg::TypeW-1:0] ReqUnusedLo = 3'd5;
  localparam logic [lrutd_pkg::TypeW-1:0] ReqUnusedMid = 3'd6;
  localparam logic [lrutd_pkg::TypeW-1:0] ReqUnusedHi = 3'd7;
  localparam int NumRandom = 1830;
  localparam int CalmTail = 250;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [lrutd_pkg::TypeW-1:0] req_type = '0;
  logic [lrutd_pkg::KeyW-1:0]  key = '0;
  logic [lrutd_pkg::SlotW-1:0] slot_in = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        found;
  logic [lrutd_pkg::SlotW-1:0] slot_out;
  logic [lrutd_pkg::KeyW-1:0]  key_out;
  logic                        created;
  int                          pending;
  int                          errors;
  bit                          calm = 1'b0;
  logic [lrutd_pkg::KeyW-1:0]  key_pool [24];

  always #4 clk_i = ~clk_i;

  lru_tag_directory DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .key_i(key), .slot_in_i(slot_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .found_o(found), .slot_out_o(slot_out), .key_out_o(key_out),
    .created_o(created)
  );

  lru_tag_directory_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .req_type_i(req_type), .key_i(key), .slot_in_i(slot_in),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .found_i(found), .slot_out_i(slot_out), .key_out_i(key_out),
    .created_i(created),
    .pending_o(pending), .errors_o(errors)
  );

  // Receiver stalls come in short bursts until the calm tail of the run.
  always @(negedge clk_i) begin
    int stall;
    if (!calm && $urandom_range(0, 5) == 0) begin
      stall = $urandom_range(1, 5);
      out_ready <= 1'b0;
      repeat (stall) @(negedge clk_i);
    end
    out_ready <= 1'b1;
  end

  // Drives one request at a falling edge and holds it until the transfer.
  // Ready is stable at the falling edge and holds for the next rising edge.
  task automatic issue(logic [lrutd_pkg::TypeW-1:0] op, logic [lrutd_pkg::KeyW-1:0] k,
                       logic [lrutd_pkg::SlotW-1:0] s);
    bit took;
    req_type = op;
    key = k;
    slot_in = s;
    in_valid = 1'b1;
    do begin
      took = in_ready;
      @(negedge clk_i);
    end while (!took);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  initial begin
    int pick;
    logic [lrutd_pkg::KeyW-1:0] k;
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: empty directory first, then fill, hit, unused request codes and evict.
    issue(lrutd_pkg::ReqLookup, 32'h1234_5678, '0);
    issue(lrutd_pkg::ReqOldest, '0, '0);
    issue(lrutd_pkg::ReqOldValid, '0, '0);
    issue(lrutd_pkg::ReqNewer, '0, 4'd0);
    issue(lrutd_pkg::ReqNewer, '0, 4'd15);
    issue(lrutd_pkg::ReqUpdate, '0, '0);
    issue(lrutd_pkg::ReqUpdate, '1, 4'd15);
    issue(lrutd_pkg::ReqUpdate, '1, '0);
    issue(lrutd_pkg::ReqLookup, '0, '0);
    issue(lrutd_pkg::ReqOldest, '0, '0);
    issue(lrutd_pkg::ReqOldValid, '1, '0);
    issue(lrutd_pkg::ReqNewer, '1, 4'd15);
    issue(lrutd_pkg::ReqNewer, '0, 4'd0);
    issue(ReqUnusedLo, '1, 4'd15);
    issue(ReqUnusedMid, '0, '0);
    issue(ReqUnusedHi, 32'hA5A5_5A5A, 4'd7);
    for (int i = 2; i < 19; i++) issue(lrutd_pkg::ReqUpdate, key_pool[i], '0);
    issue(lrutd_pkg::ReqOldest, '0, '0);
    issue(lrutd_pkg::ReqLookup, '0, '0);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - CalmTail) calm = 1'b1;
      k = ($urandom_range(0, 4) == 0) ? lrutd_pkg::KeyW'($urandom()) :
          key_pool[$urandom_range(0, 23)];
      pick = $urandom_range(0, 99);
      if (pick < 30) issue(lrutd_pkg::ReqLookup, k, lrutd_pkg::SlotW'($urandom()));
      else if (pick < 60) issue(lrutd_pkg::ReqUpdate, k, lrutd_pkg::SlotW'($urandom()));
      else if (pick < 70) issue(lrutd_pkg::ReqOldest, k, lrutd_pkg::SlotW'($urandom()));
      else if (pick < 80) issue(lrutd_pkg::ReqOldValid, k, lrutd_pkg::SlotW'($urandom()));
      else if (pick < 96) issue(lrutd_pkg::ReqNewer, k, lrutd_pkg::SlotW'($urandom()));
      else issue(lrutd_pkg::TypeW'($urandom_range(ReqUnusedLo, ReqUnusedHi)), k,
                 lrutd_pkg::SlotW'($urandom()));
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (lrutd_pkg::Entries + 10) @(negedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #4ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

@@ lru_tag_directory.f @@
hw/rtl/lrutd_pkg.sv
hw/rtl/lru_tag_directory.sv
tb/sv/lru_tag_directory_checker.sv
tb/sv/tb_lru_tag_directory.sv
